@@ src/gsa_pkg.sv @@
// Shared types and constants of the generational slot allocator.
package gsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int GEN_W     = 16;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CAP_W     = $clog2(MAX_SLOTS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX = 3'd2;
  localparam logic [2:0] ST_GEN_MISS  = 3'd3;
  localparam logic [2:0] ST_INACTIVE  = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef enum logic [2:0] {
    K_CREATE,
    K_DESTROY,
    K_LOOKUP,
    K_BAD_INDEX,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [GEN_W-1:0]   gen;
  } cmd_t;

  typedef struct packed {
    logic               active;
    logic               link_valid;
    logic [IDX_W-1:0]   link;
    logic [GEN_W-1:0]   gen;
  } entry_t;

  typedef enum logic {
    BS_IDLE,
    BS_EXEC
  } back_state_t;

endpackage

@@ src/generational_slot_allocator_unit.sv @@
// Top level of the generational slot allocator: front end, queue and back end.
// A request accepted into the queue passes the table read register and then the result register.
// The back end starts a new request only after the last one has executed, as the slot table port is read then written.
// The back end reads a table entry in one cycle and writes it back in the next.
// Reset (rst, synchronous) empties the queue and free list, zeroes the issue count, sets
// capacity to 1024; the table has no clearing pass, as entries past the issue count are ignored.
module generational_slot_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [gsa_pkg::CAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [gsa_pkg::IDX_W-1:0] slot_index,
  input  logic [gsa_pkg::GEN_W-1:0] slot_generation,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [gsa_pkg::IDX_W-1:0] handle_index,
  output logic [gsa_pkg::GEN_W-1:0] handle_generation,
  output logic                      found
);

  // The front end decodes each request word and flags destroy and lookup indices
  // at or beyond capacity, which the back end answers with a bad-index status.
  logic                      q_push;
  logic                      q_not_full;
  logic                      q_pop;
  logic                      q_not_empty;
  gsa_pkg::cmd_t             push_cmd;
  gsa_pkg::cmd_t             head_cmd;
  logic [gsa_pkg::CAP_W-1:0] eff_cap;

  gsa_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .slot_index      (slot_index),
    .slot_generation (slot_generation),
    .q_ready         (q_not_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd),
    .eff_cap         (eff_cap)
  );

  // The queue lets the front end keep taking words while a result waits
  // for the consumer.
  gsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // The back end owns the slot table, free list and issue count; the free-list head chains from
  // one command to the next, so commands are executed one at a time.
  gsa_back u_back (
    .clk               (clk),
    .rst               (rst),
    .eff_cap           (eff_cap),
    .q_valid           (q_not_empty),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .found             (found)
  );

endmodule

@@ src/gsa_front.sv @@
// Front end: capacity register, request intake and classification.
module gsa_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [gsa_pkg::CAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [gsa_pkg::IDX_W-1:0] slot_index,
  input  logic [gsa_pkg::GEN_W-1:0] slot_generation,
  input  logic                      q_ready,
  output logic                      q_push,
  output gsa_pkg::cmd_t             q_cmd,
  output logic [gsa_pkg::CAP_W-1:0] eff_cap
);

  logic [gsa_pkg::CAP_W-1:0] capacity;
  logic                      bad_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= gsa_pkg::CAP_W'(gsa_pkg::MAX_SLOTS);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Values above the table size act as the table size.
  assign eff_cap = (capacity > gsa_pkg::CAP_W'(gsa_pkg::MAX_SLOTS)) ?
                   gsa_pkg::CAP_W'(gsa_pkg::MAX_SLOTS) : capacity;

  assign bad_idx  = gsa_pkg::CAP_W'(slot_index) >= eff_cap;
  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  always_comb begin
    q_cmd.idx = slot_index;
    q_cmd.gen = slot_generation;
    case (op)
      gsa_pkg::OP_CREATE:  q_cmd.kind = gsa_pkg::K_CREATE;
      gsa_pkg::OP_DESTROY: q_cmd.kind = bad_idx ? gsa_pkg::K_BAD_INDEX : gsa_pkg::K_DESTROY;
      gsa_pkg::OP_LOOKUP:  q_cmd.kind = bad_idx ? gsa_pkg::K_BAD_INDEX : gsa_pkg::K_LOOKUP;
      default:             q_cmd.kind = gsa_pkg::K_NOP;
    endcase
  end

endmodule

@@ src/gsa_queue.sv @@
// Small command queue between the front and back ends.
module gsa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gsa_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output gsa_pkg::cmd_t head_cmd
);

  gsa_pkg::cmd_t                slots [gsa_pkg::QUEUE_DEPTH];
  logic [gsa_pkg::QPTR_W-1:0]   wr_ptr;
  logic [gsa_pkg::QPTR_W-1:0]   rd_ptr;
  logic [gsa_pkg::QCNT_W-1:0]   count;

  assign not_full  = count != gsa_pkg::QCNT_W'(gsa_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= gsa_pkg::QCNT_W'(gsa_pkg::QUEUE_DEPTH))
    else $error("command queue count exceeds its depth");

endmodule

@@ src/gsa_back.sv @@
// Back end: slot table, free list, issue counter and result register.
module gsa_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gsa_pkg::CAP_W-1:0] eff_cap,
  input  logic                      q_valid,
  input  gsa_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [gsa_pkg::IDX_W-1:0] handle_index,
  output logic [gsa_pkg::GEN_W-1:0] handle_generation,
  output logic                      found
);

  gsa_pkg::entry_t           table_mem [gsa_pkg::MAX_SLOTS];
  gsa_pkg::entry_t           rd_entry;
  gsa_pkg::cmd_t             cmd;
  gsa_pkg::back_state_t      state;
  gsa_pkg::back_state_t      state_next;
  logic [gsa_pkg::IDX_W-1:0] rd_addr;
  logic [gsa_pkg::IDX_W-1:0] free_head;
  logic [gsa_pkg::IDX_W-1:0] free_head_next;
  logic                      free_nonempty;
  logic                      free_nonempty_next;
  logic [gsa_pkg::CAP_W-1:0] issued;
  logic [gsa_pkg::CAP_W-1:0] issued_next;
  logic                      mem_we;
  logic [gsa_pkg::IDX_W-1:0] wr_addr;
  gsa_pkg::entry_t           wr_data;
  logic [2:0]                res_status;
  logic [gsa_pkg::IDX_W-1:0] res_idx;
  logic [gsa_pkg::GEN_W-1:0] res_gen;
  logic                      res_found;
  logic                      was_issued;
  logic [gsa_pkg::GEN_W-1:0] cur_gen;
  logic                      cur_active;

  // The result register is free in the execute cycle whenever we pop.
  assign q_pop   = (state == gsa_pkg::BS_IDLE) && q_valid && (!out_valid || out_ready);
  assign rd_addr = (q_cmd.kind == gsa_pkg::K_CREATE) ? free_head : q_cmd.idx;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_entry <= table_mem[rd_addr];
      cmd      <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    case (state)
      gsa_pkg::BS_IDLE: state_next = q_pop ? gsa_pkg::BS_EXEC : gsa_pkg::BS_IDLE;
      gsa_pkg::BS_EXEC: state_next = gsa_pkg::BS_IDLE;
      default:          state_next = gsa_pkg::BS_IDLE;
    endcase
  end

  // Entries at or beyond the issue count were never written.
  assign was_issued = gsa_pkg::CAP_W'(cmd.idx) < issued;
  assign cur_gen    = was_issued ? rd_entry.gen : '0;
  assign cur_active = was_issued & rd_entry.active;

  always_comb begin
    mem_we             = 1'b0;
    wr_addr            = cmd.idx;
    wr_data            = rd_entry;
    free_head_next     = free_head;
    free_nonempty_next = free_nonempty;
    issued_next        = issued;
    res_status         = gsa_pkg::ST_NOT_FOUND;
    res_idx            = '0;
    res_gen            = '0;
    res_found          = 1'b0;
    if (state == gsa_pkg::BS_EXEC) begin
      case (cmd.kind)
        gsa_pkg::K_CREATE: begin
          if (free_nonempty) begin
            mem_we             = 1'b1;
            wr_addr            = free_head;
            wr_data.active     = 1'b1;
            free_head_next     = rd_entry.link;
            free_nonempty_next = rd_entry.link_valid;
            res_status         = gsa_pkg::ST_OK;
            res_idx            = free_head;
            res_gen            = rd_entry.gen;
          end else if (issued < eff_cap) begin
            mem_we             = 1'b1;
            wr_addr            = issued[gsa_pkg::IDX_W-1:0];
            wr_data            = '{active: 1'b1, link_valid: 1'b0, link: '0, gen: '0};
            issued_next        = issued + 1'b1;
            res_status         = gsa_pkg::ST_OK;
            res_idx            = issued[gsa_pkg::IDX_W-1:0];
          end else begin
            res_status         = gsa_pkg::ST_FULL;
          end
        end
        gsa_pkg::K_DESTROY: begin
          if (cur_gen != cmd.gen) begin
            res_status = gsa_pkg::ST_GEN_MISS;
          end else if (!cur_active) begin
            res_status = gsa_pkg::ST_INACTIVE;
          end else begin
            mem_we             = 1'b1;
            wr_data            = '{active: 1'b0, link_valid: free_nonempty,
                                   link: free_head, gen: rd_entry.gen + 1'b1};
            free_head_next     = cmd.idx;
            free_nonempty_next = 1'b1;
            res_status         = gsa_pkg::ST_OK;
          end
        end
        gsa_pkg::K_LOOKUP: begin
          if (was_issued && (rd_entry.gen == cmd.gen)) begin
            res_status = gsa_pkg::ST_OK;
            res_idx    = cmd.idx;
            res_gen    = rd_entry.gen;
            res_found  = 1'b1;
          end
        end
        gsa_pkg::K_BAD_INDEX: res_status = gsa_pkg::ST_BAD_INDEX;
        default:              res_status = gsa_pkg::ST_NOT_FOUND;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gsa_pkg::BS_IDLE;
      free_head     <= '0;
      free_nonempty <= 1'b0;
      issued        <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      free_head     <= free_head_next;
      free_nonempty <= free_nonempty_next;
      issued        <= issued_next;
      if (state == gsa_pkg::BS_EXEC) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gsa_pkg::BS_EXEC) begin
      status            <= res_status;
      handle_index      <= res_idx;
      handle_generation <= res_gen;
      found             <= res_found;
    end
  end

  a_result_reg_free: assert property (@(posedge clk) disable iff (rst)
    state == gsa_pkg::BS_EXEC |-> !out_valid)
    else $error("result register still occupied when a request completes");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    state == gsa_pkg::BS_IDLE |=> $stable(issued) && $stable(free_head)
                                  && $stable(free_nonempty))
    else $error("allocator state changed without a request in execution");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issued <= gsa_pkg::CAP_W'(gsa_pkg::MAX_SLOTS))
    else $error("issue count exceeds the table size");

endmodule
